[src/phfi_pkg.sv]
// ----------------------------------------------------------------------------
// phfi_pkg: shared types and constants for the pair hash find-or-insert block
// Hash constants, table geometry, datapath operation codes, the hash and
// remix micro-programs, and the command and status words between controller
// and datapath.
// ----------------------------------------------------------------------------
package phfi_pkg;

  localparam logic [63:0] MURMUR_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MURMUR_SHIFT = 47;
  localparam logic [63:0] PAIR_SEED    = 64'h000000005bd1e995;
  localparam logic [63:0] HASH_INIT    = PAIR_SEED ^ {MURMUR_MUL[59:0], 4'b0000};
  localparam logic [31:0] MUL_LO       = MURMUR_MUL[31:0];
  localparam logic [31:0] MUL_HI       = MURMUR_MUL[63:32];

  localparam int TABLE_DEPTH = 1024;
  localparam int IDXW        = $clog2(TABLE_DEPTH);
  localparam int CNTW        = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_LOAD_OFF,
    OP_MUL,
    OP_XSH,
    OP_XORH,
    OP_SAVEH,
    OP_R1,
    OP_R2,
    OP_R3,
    OP_R4,
    OP_R5,
    OP_R6,
    OP_R7
  } op_t;

  typedef enum logic [1:0] {
    RES_INSERT,
    RES_FOUND,
    RES_FULL
  } res_kind_t;

  typedef struct packed {
    logic      load_in;
    op_t       op;
    logic      mul_start;
    logic      mod_start;
    logic      rd_issue;
    logic      slot_adv;
    logic      wr_ins;
    logic      res_load;
    res_kind_t res_kind;
    logic      clr_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic mod_done;
    logic slot_empty;
    logic slot_match;
    logic out_busy;
    logic clr_last;
  } dp_stat_t;

  function automatic op_t prog_op(input logic remix, input logic [3:0] step);
    op_t o;
    o = OP_NONE;
    if (remix) begin
      case (step)
        4'd0: o = OP_LOAD_OFF;
        4'd1: o = OP_R1;
        4'd2: o = OP_R2;
        4'd3: o = OP_R3;
        4'd4: o = OP_R4;
        4'd5: o = OP_R5;
        4'd6: o = OP_R6;
        4'd7: o = OP_R7;
        default: o = OP_NONE;
      endcase
    end else begin
      case (step)
        4'd0:  o = OP_LOAD_A;
        4'd1:  o = OP_MUL;
        4'd2:  o = OP_XSH;
        4'd3:  o = OP_MUL;
        4'd4:  o = OP_XORH;
        4'd5:  o = OP_MUL;
        4'd6:  o = OP_SAVEH;
        4'd7:  o = OP_LOAD_B;
        4'd8:  o = OP_MUL;
        4'd9:  o = OP_XSH;
        4'd10: o = OP_MUL;
        4'd11: o = OP_XORH;
        4'd12: o = OP_MUL;
        4'd13: o = OP_XSH;
        4'd14: o = OP_MUL;
        4'd15: o = OP_XSH;
        default: o = OP_NONE;
      endcase
    end
    return o;
  endfunction

  function automatic logic prog_last(input logic remix, input logic [3:0] step);
    return remix ? (step == 4'd7) : (step == 4'd15);
  endfunction

endpackage

[src/phfi_mul.sv]
// ----------------------------------------------------------------------------
// phfi_mul: iterative 64-bit multiply by the hash constant
// Low 64 bits of the product from three 32x32 partial products, one per
// cycle, summed into a registered result with a done pulse.
// ----------------------------------------------------------------------------
module phfi_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  output logic [63:0] res,
  output logic        done
);

  logic [1:0]  cnt;
  logic [63:0] a_q;
  logic [63:0] prod;
  logic [63:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cnt)
        2'd0: begin
          if (start) begin
            a_q  <= a;
            prod <= a[31:0] * phfi_pkg::MUL_LO;
            cnt  <= 2'd1;
          end
        end
        2'd1: begin
          sum  <= prod;
          prod <= a_q[31:0] * phfi_pkg::MUL_HI;
          cnt  <= 2'd2;
        end
        2'd2: begin
          sum  <= sum + {prod[31:0], 32'b0};
          prod <= a_q[63:32] * phfi_pkg::MUL_LO;
          cnt  <= 2'd3;
        end
        2'd3: begin
          res  <= sum + {prod[31:0], 32'b0};
          done <= 1'b1;
          cnt  <= 2'd0;
        end
        default: cnt <= 2'd0;
      endcase
    end
  end

endmodule

[src/phfi_mod.sv]
// ----------------------------------------------------------------------------
// phfi_mod: reduction of the hash word modulo the table depth
// The depth is a power of two, so the reduction keeps the low index bits;
// remainder and done pulse are registered in the cycle after start.
// ----------------------------------------------------------------------------
module phfi_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [phfi_pkg::IDXW-1:0] x,
  output logic [phfi_pkg::IDXW-1:0] rem,
  output logic                      done
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        rem <= x;
      end
    end
  end

endmodule

[src/phfi_datapath.sv]
// ----------------------------------------------------------------------------
// phfi_datapath: hash registers, slot store and result register
// Runs the operations the controller commands, holds the key and valid
// memories and the output word register.
// ----------------------------------------------------------------------------
module phfi_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  phfi_pkg::ctrl_cmd_t   cmd,
  output phfi_pkg::dp_stat_t    stat,
  input  logic [127:0]          in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [23:0]           out_data,
  output logic [1:0]            out_user
);

  localparam int TABLE_DEPTH = phfi_pkg::TABLE_DEPTH;
  localparam int IDXW = phfi_pkg::IDXW;
  localparam int CNTW = phfi_pkg::CNTW;
  localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(TABLE_DEPTH - 1);

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] h;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [IDXW-1:0] offset;
  logic [IDXW-1:0] slot;
  logic [IDXW-1:0] clr_addr;
  logic [CNTW-1:0] count;

  logic [63:0] left_mem  [TABLE_DEPTH];
  logic [63:0] right_mem [TABLE_DEPTH];
  logic        valid_mem [TABLE_DEPTH];
  logic [63:0] lq;
  logic [63:0] rq;
  logic        vq;

  logic [63:0]     mul_res;
  logic            mul_done;
  logic [IDXW-1:0] mod_res;
  logic            mod_done;

  phfi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (acc),
    .res   (mul_res),
    .done  (mul_done)
  );

  phfi_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .x     (acc[IDXW-1:0]),
    .rem   (mod_res),
    .done  (mod_done)
  );

  always_comb begin
    acc_next = acc;
    case (cmd.op)
      phfi_pkg::OP_LOAD_A:   acc_next = a_q;
      phfi_pkg::OP_LOAD_B:   acc_next = b_q;
      phfi_pkg::OP_LOAD_OFF: acc_next = 64'(offset);
      phfi_pkg::OP_XSH:      acc_next = acc ^ (acc >> phfi_pkg::MURMUR_SHIFT);
      phfi_pkg::OP_XORH:     acc_next = acc ^ h;
      phfi_pkg::OP_R1:       acc_next = (~acc) + (acc << 21);
      phfi_pkg::OP_R2:       acc_next = acc ^ 64'($signed(acc) >>> 24);
      phfi_pkg::OP_R3:       acc_next = acc + (acc << 3) + (acc << 8);
      phfi_pkg::OP_R4:       acc_next = acc ^ 64'($signed(acc) >>> 14);
      phfi_pkg::OP_R5:       acc_next = acc + (acc << 2) + (acc << 4);
      phfi_pkg::OP_R6:       acc_next = acc ^ 64'($signed(acc) >>> 28);
      phfi_pkg::OP_R7:       acc_next = acc + (acc << 31);
      default:               acc_next = acc;
    endcase
    if (mul_done) begin
      acc_next = mul_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_q <= in_data[63:0];
      b_q <= in_data[127:64];
      h   <= phfi_pkg::HASH_INIT;
    end else if (cmd.op == phfi_pkg::OP_SAVEH) begin
      h <= acc;
    end
    acc <= acc_next;
    if (mod_done) begin
      offset <= mod_res;
      slot   <= mod_res;
    end else if (cmd.slot_adv) begin
      slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      valid_mem[clr_addr] <= 1'b0;
    end else if (cmd.wr_ins) begin
      valid_mem[slot] <= 1'b1;
      left_mem[slot]  <= a_q;
      right_mem[slot] <= b_q;
    end
    if (cmd.rd_issue) begin
      vq <= valid_mem[slot];
      lq <= left_mem[slot];
      rq <= right_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.wr_ins) begin
        count <= count + 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data[20:10] <= count;
      out_data[23:21] <= 3'b000;
      case (cmd.res_kind)
        phfi_pkg::RES_INSERT: begin
          out_data[9:0] <= slot;
          out_user      <= 2'b00;
        end
        phfi_pkg::RES_FOUND: begin
          out_data[9:0] <= slot;
          out_user      <= 2'b01;
        end
        default: begin
          out_data[9:0] <= 10'd0;
          out_user      <= 2'b10;
        end
      endcase
    end
  end

  always_comb begin
    stat.mul_done   = mul_done;
    stat.mod_done   = mod_done;
    stat.slot_empty = !vq;
    stat.slot_match = (lq == a_q) && (rq == b_q);
    stat.out_busy   = out_valid && !out_ready;
    stat.clr_last   = (clr_addr == LAST_SLOT);
  end

  a_ins_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_ins |-> !vq) else $error("insert into occupied slot");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(TABLE_DEPTH)) else $error("entry count beyond depth");
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(out_valid && !out_ready)) else $error("result overwritten");
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    mod_done |=> (CNTW'(offset) < CNTW'(TABLE_DEPTH))) else $error("offset out of range");

endmodule

[src/phfi_ctrl.sv]
// ----------------------------------------------------------------------------
// phfi_ctrl: sequencer for the pair hash find-or-insert block
// Steps through clearing, hashing, reduction, probing and remixing, and
// hands each result to the output register.
// ----------------------------------------------------------------------------
module phfi_ctrl #(
  parameter int LINE_SLOTS  = 8,
  parameter int PROBE_LINES = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  phfi_pkg::dp_stat_t  stat,
  output phfi_pkg::ctrl_cmd_t cmd
);

  localparam int SW = $clog2(LINE_SLOTS + 1);
  localparam int LW = $clog2(PROBE_LINES + 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_EXEC  = 10'b0000000100,
    S_MULW  = 10'b0000001000,
    S_MOD   = 10'b0000010000,
    S_MODW  = 10'b0000100000,
    S_RD    = 10'b0001000000,
    S_CMP   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_HOLD  = 10'b1000000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [3:0]          step;
  logic [3:0]          step_next;
  logic                remix;
  logic                remix_next;
  logic [SW-1:0]       si;
  logic [SW-1:0]       si_next;
  logic [LW-1:0]       li;
  logic [LW-1:0]       li_next;
  phfi_pkg::res_kind_t kind;
  phfi_pkg::res_kind_t kind_next;
  phfi_pkg::op_t       cur_op;
  logic                cur_last;

  always_comb begin
    cur_op   = phfi_pkg::prog_op(remix, step);
    cur_last = phfi_pkg::prog_last(remix, step);
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    remix_next   = remix;
    si_next      = si;
    li_next      = li;
    kind_next    = kind;
    cmd          = '0;
    cmd.op       = phfi_pkg::OP_NONE;
    cmd.res_kind = kind;
    in_ready     = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          step_next   = 4'd0;
          remix_next  = 1'b0;
          li_next     = '0;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cur_op == phfi_pkg::OP_MUL) begin
          cmd.mul_start = 1'b1;
          state_next    = S_MULW;
        end else begin
          cmd.op = cur_op;
          if (cur_last) begin
            state_next = S_MOD;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      S_MULW: begin
        if (stat.mul_done) begin
          if (cur_last) begin
            state_next = S_MOD;
          end else begin
            step_next  = step + 4'd1;
            state_next = S_EXEC;
          end
        end
      end
      S_MOD: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MODW;
      end
      S_MODW: begin
        if (stat.mod_done) begin
          si_next    = '0;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_CMP;
      end
      S_CMP: begin
        if (stat.slot_empty) begin
          cmd.wr_ins = 1'b1;
          kind_next  = phfi_pkg::RES_INSERT;
          state_next = S_OUT;
        end else if (stat.slot_match) begin
          kind_next  = phfi_pkg::RES_FOUND;
          state_next = S_OUT;
        end else if (si == SW'(LINE_SLOTS - 1)) begin
          if (li == LW'(PROBE_LINES - 1)) begin
            kind_next  = phfi_pkg::RES_FULL;
            state_next = S_OUT;
          end else begin
            li_next    = li + 1'b1;
            remix_next = 1'b1;
            step_next  = 4'd0;
            state_next = S_EXEC;
          end
        end else begin
          si_next      = si + 1'b1;
          cmd.slot_adv = 1'b1;
          state_next   = S_RD;
        end
      end
      S_OUT: begin
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= 4'd0;
      remix <= 1'b0;
      si    <= '0;
      li    <= '0;
      kind  <= phfi_pkg::RES_INSERT;
    end else begin
      state <= state_next;
      step  <= step_next;
      remix <= remix_next;
      si    <= si_next;
      li    <= li_next;
      kind  <= kind_next;
    end
  end

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_RD) else $error("compare without read");
  a_mul_single: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> state == S_MULW) else $error("multiply not awaited");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> state == S_IDLE) else $error("word taken while busy");

endmodule

[src/pair_hash_find_or_insert.sv]
// ----------------------------------------------------------------------------
// pair_hash_find_or_insert: find-or-insert of 64-bit pairs in a hash table
// Hashes each pair, probes lines of slots and stores or reports the pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis carries one pair per word; output channel m_axis
//   returns one result word per input word, in order.
//   After reset the valid store is swept clear, one slot a cycle, over
//   all 1024 slots; s_axis_tready stays low until the sweep ends. One
//   word is worked on at a time. The hash takes 16 steps: nine shift,
//   xor, load and save steps and seven multiplies built from 32x32
//   partial products. The slot offset is the low 10 hash bits, taken
//   through the reduction register. Each probed slot takes a read state
//   and a compare state on the single memory read port, and each further
//   line costs 8 remix steps plus another reduction. A result shows on
//   m_axis in the same cycle as s_axis_tready returns; a search probes at
//   most 80 slots.
//   The result sits in an output register; a stalled m_axis holds it, and
//   the block takes the next word meanwhile but waits with the following
//   result until the register is free.
// ----------------------------------------------------------------------------
module pair_hash_find_or_insert #(
  parameter int LINE_SLOTS  = 8,
  parameter int PROBE_LINES = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // left_word, right_word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,  // slot_index, entry_count, zero pad
  output logic [1:0]   m_axis_tuser   // was_found, table_full
);

  phfi_pkg::ctrl_cmd_t cmd;
  phfi_pkg::dp_stat_t  stat;

  phfi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

  phfi_ctrl #(
    .LINE_SLOTS  (LINE_SLOTS),
    .PROBE_LINES (PROBE_LINES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

endmodule

[tb/sv/tb_pair_hash_find_or_insert.sv]
// ----------------------------------------------------------------------------
// tb_pair_hash_find_or_insert: self-checking bench for the pair hash table
// Streams 64-bit pairs into the block with random source gaps and sink
// stalls. It predicts each result from its own copy of the table and checks
// the results in order. The stimulus mixes fresh pairs, repeats, and a burst
// of pairs that share one start offset so that the probe lines fill and the
// table reports full.
// ----------------------------------------------------------------------------
module tb_pair_hash_find_or_insert;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH       = 1024;
  localparam int          SLOTS       = 8;
  localparam int          LINES       = 10;
  localparam logic [63:0] MIX_MUL     = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] HASH_SEED   = 64'h000000005bd1e995;
  localparam int          RANDOM_WORDS = 650;
  localparam int          CLASH_WORDS  = 90;
  localparam int          MAX_CYCLES   = 4000000;
  localparam int          DRAIN_CYCLES = 1500;

  typedef struct packed {
    logic [9:0]  slot;
    logic        found;
    logic        full;
    logic [10:0] count;
  } lookup_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  logic [63:0]  tbl_left [DEPTH];
  logic [63:0]  tbl_right[DEPTH];
  logic         tbl_used [DEPTH];
  logic [10:0]  tbl_count;

  logic [127:0] pending_pairs[$];
  logic [127:0] sent_pairs[$];
  lookup_res_t  expected_res[$];
  int           total_words = 0;
  int           accepted = 0;
  int           errors = 0;
  int           cycles = 0;
  int           src_wait = 0;
  int           sink_wait = 0;

  pair_hash_find_or_insert uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] murmur_step(logic [63:0] h, logic [63:0] k);
    k = k * MIX_MUL;
    k = k ^ (k >> 47);
    k = k * MIX_MUL;
    h = h ^ k;
    return h * MIX_MUL;
  endfunction

  function automatic logic [63:0] pair_hash(logic [63:0] a, logic [63:0] b);
    logic [63:0] h;
    h = HASH_SEED ^ (64'd16 * MIX_MUL);
    h = murmur_step(h, a);
    h = murmur_step(h, b);
    h = h ^ (h >> 47);
    h = h * MIX_MUL;
    return h ^ (h >> 47);
  endfunction

  function automatic logic [63:0] remix_offset(logic [63:0] k);
    k = (~k) + (k << 21);
    k = k ^ 64'($signed(k) >>> 24);
    k = (k + (k << 3)) + (k << 8);
    k = k ^ 64'($signed(k) >>> 14);
    k = (k + (k << 2)) + (k << 4);
    k = k ^ 64'($signed(k) >>> 28);
    return k + (k << 31);
  endfunction

  function automatic lookup_res_t find_or_insert(logic [63:0] a, logic [63:0] b);
    lookup_res_t r;
    logic [63:0] off;
    int          s;
    off = pair_hash(a, b) % DEPTH;
    for (int ln = 0; ln < LINES; ln++) begin
      for (int i = 0; i < SLOTS; i++) begin
        s = int'((off + i) % DEPTH);
        if (!tbl_used[s]) begin
          tbl_used[s]  = 1'b1;
          tbl_left[s]  = a;
          tbl_right[s] = b;
          tbl_count    = tbl_count + 11'd1;
          r = '{slot: s[9:0], found: 1'b0, full: 1'b0, count: tbl_count};
          return r;
        end
        if (tbl_left[s] == a && tbl_right[s] == b) begin
          r = '{slot: s[9:0], found: 1'b1, full: 1'b0, count: tbl_count};
          return r;
        end
      end
      off = remix_offset(off) % DEPTH;
    end
    r = '{slot: 10'd0, found: 1'b0, full: 1'b1, count: tbl_count};
    return r;
  endfunction

  function automatic int draw_gap(int n);
    return ((n / 60) % 3 == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin : drive
      logic fire;
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        expected_res.push_back(find_or_insert(s_axis_tdata[63:0], s_axis_tdata[127:64]));
        accepted++;
      end
      if (!s_axis_tvalid || fire) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          s_axis_tdata  <= pending_pairs.pop_front();
          s_axis_tvalid <= 1'b1;
          src_wait = draw_gap(accepted);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin : observe
      lookup_res_t got, want;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{slot: m_axis_tdata[9:0], found: m_axis_tuser[0], full: m_axis_tuser[1],
                count: m_axis_tdata[20:10]};
        if (expected_res.size() == 0) begin
          if (errors < 10) $display("unexpected result word %h", got);
          errors++;
        end else begin
          want = expected_res.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: slot %0d/%0d found %0b/%0b full %0b/%0b count %0d/%0d",
                       want.slot, got.slot, want.found, got.found, want.full, got.full,
                       want.count, got.count);
            errors++;
          end
        end
        sink_wait = draw_gap(accepted + 30);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("tb_pair_hash_find_or_insert NOT OK");
      $finish;
    end
  end

  task automatic queue_pair(logic [63:0] a, logic [63:0] b);
    pending_pairs.push_back({b, a});
    sent_pairs.push_back({b, a});
    total_words++;
  endtask

  initial begin : stimulus
    logic [63:0] a, b, target;
    int          clash_at, clashes;
    for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
    tbl_count = '0;

    queue_pair(64'd0, 64'd0);
    queue_pair('1, '1);
    queue_pair(64'd0, '1);
    queue_pair('1, 64'd0);
    queue_pair(64'd0, 64'd0);
    queue_pair('1, '1);
    queue_pair(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    queue_pair(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    queue_pair(64'h8000000000000000, 64'd1);
    queue_pair(64'd1, 64'h8000000000000000);
    queue_pair(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    queue_pair(64'd0, '1);

    clash_at = $urandom_range(100, RANDOM_WORDS - CLASH_WORDS - 100);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == clash_at) begin
        target  = 64'($urandom_range(0, DEPTH - 1));
        clashes = 0;
        while (clashes < CLASH_WORDS) begin
          a = {$urandom, $urandom};
          b = {$urandom, $urandom};
          if (pair_hash(a, b) % DEPTH == target) begin
            queue_pair(a, b);
            clashes++;
          end
        end
      end
      if ($urandom_range(0, 9) < 3) begin
        {b, a} = sent_pairs[$urandom_range(0, sent_pairs.size() - 1)];
        queue_pair(a, b);
      end else begin
        queue_pair({$urandom, $urandom}, {$urandom, $urandom});
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (accepted == total_words && expected_res.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0)
      $display("tb_pair_hash_find_or_insert OK");
    else
      $display("tb_pair_hash_find_or_insert NOT OK");
    $finish;
  end

endmodule
